// ===== rtl/cwmm_pkg.sv =====
// Shared types and constants for the cascaded window min/max normalizer.
// No dependencies; every other file of the block but cwmm_fifo imports this package.
package cwmm_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int TIME_W      = 63;
   localparam int NORM_W      = 16;
   localparam int LIMIT_W     = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LIM_LONG  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIM_MID   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIM_SHORT = 2'd2;

   // reset values of the age limits, in minutes
   localparam logic [LIMIT_W-1:0] LIM_LONG_RST  = 16'd60;
   localparam logic [LIMIT_W-1:0] LIM_MID_RST   = 16'd15;
   localparam logic [LIMIT_W-1:0] LIM_SHORT_RST = 16'd5;

   // ratio of one in Q0.16, saturated
   localparam logic [NORM_W-1:0] NORM_ONE = 16'hFFFF;

   typedef struct packed {
      logic [LIMIT_W-1:0] lim_long;
      logic [LIMIT_W-1:0] lim_mid;
      logic [LIMIT_W-1:0] lim_short;
   } limits_type;

endpackage

// ===== rtl/cwmm_fifo.sv =====
// Small queue between the sample front end and the window engine.
// Depends on nothing; width and depth are parameters.
module cwmm_fifo #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/cwmm_front.sv =====
// Front end: takes samples, maps them to offset-binary and tags the seed sample.
// Depends on cwmm_pkg; feeds cwmm_fifo.
module cwmm_front import cwmm_pkg::*; #(
   parameter int VALUE_BITS = 32,
   parameter int ENTRY_W    = 1 + 32 + 63
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_value,
   input  logic [TIME_W-1:0]          req_sample_time,
   output logic                       push,
   output logic [ENTRY_W-1:0]         push_data,
   input  logic                       full
);

   logic                  seeded_ff, seeded_in;
   logic [VALUE_BITS-1:0] wrapped;
   logic [VALUE_BITS-1:0] biased;

   assign req_stall = full;
   assign push      = req_valid && !full;

   // sign-extend or wrap to the value width, then flip the sign bit
   assign wrapped = VALUE_BITS'(req_sample_value);
   assign biased  = {~wrapped[VALUE_BITS-1], wrapped[VALUE_BITS-2:0]};

   assign push_data = {!seeded_ff, biased, req_sample_time};

   // the first accepted sample after reset seeds every window
   always_comb begin
      seeded_in = seeded_ff;
      if (push) begin
         seeded_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 1'b0;
      end else begin
         seeded_ff <= seeded_in;
      end
   end

endmodule

// ===== rtl/cwmm_div.sv =====
// Restoring fraction divider: floor(num * 65536 / den) for num < den.
// Depends on cwmm_pkg; one quotient bit per cycle.
module cwmm_div import cwmm_pkg::*; #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] num,
   input  logic [VALUE_BITS-1:0] den,
   output logic                  done,
   output logic [NORM_W-1:0]     quot
);

   localparam int CNT_W = $clog2(NORM_W);

   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] den_ff, den_in;
   logic [NORM_W-1:0]     quot_ff, quot_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [VALUE_BITS:0]   shifted;
   logic [VALUE_BITS:0]   diff;
   logic                  fits;

   assign done = done_ff;
   assign quot = quot_ff;

   // one trial subtract per cycle
   assign shifted = {rem_ff, 1'b0};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = (shifted >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         den_in  = den;
         quot_in = '0;
         cnt_in  = CNT_W'(NORM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
         quot_in = {quot_ff[NORM_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

endmodule

// ===== rtl/cwmm_window.sv =====
// Back end: ages and shrinks the window cascade, normalizes, holds the result.
// Depends on cwmm_pkg; drives cwmm_div and pops cwmm_fifo.
module cwmm_window import cwmm_pkg::*; #(
   parameter int WINDOWS          = 4,
   parameter int VALUE_BITS       = 32,
   parameter int TICKS_PER_MINUTE = 600000000,
   parameter int ENTRY_W          = 1 + 32 + 63
) (
   input  logic                       clock,
   input  logic                       reset,
   input  limits_type                 limits,
   input  logic                       fifo_empty,
   input  logic [ENTRY_W-1:0]         fifo_data,
   output logic                       fifo_pop,
   output logic                       div_start,
   output logic [VALUE_BITS-1:0]      div_num,
   output logic [VALUE_BITS-1:0]      div_den,
   input  logic                       div_done,
   input  logic [NORM_W-1:0]          div_quot,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [NORM_W-1:0]          rsp_normalized,
   output logic signed [SAMPLE_W-1:0] rsp_window_min,
   output logic signed [SAMPLE_W-1:0] rsp_window_max,
   output logic                       rsp_flat
);

   localparam int IDX_W = $clog2(WINDOWS);
   localparam int TPM_W = $clog2(TICKS_PER_MINUTE + 1);
   localparam int THR_W = LIMIT_W + 1 + TPM_W;
   localparam int VB    = VALUE_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_AGE,
      ST_SHRINK,
      ST_CLAMP,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // window stores, written before any read
   logic [VB-1:0]     min_v_ff [WINDOWS];
   logic [TIME_W-1:0] min_t_ff [WINDOWS];
   logic [VB-1:0]     max_v_ff [WINDOWS];
   logic [TIME_W-1:0] max_t_ff [WINDOWS];

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [VB-1:0]     cur_v_ff, cur_v_in;
   logic [TIME_W-1:0] cur_t_ff, cur_t_in;
   logic [TIME_W-1:0] thr_ff, thr_in;
   logic              age_min_ff, age_min_in;
   logic              age_max_ff, age_max_in;

   // aged and shrunk values of the next shorter window
   logic [VB-1:0]     ca_min_v_ff, ca_min_v_in, ca_max_v_ff, ca_max_v_in;
   logic [TIME_W-1:0] ca_min_t_ff, ca_min_t_in, ca_max_t_ff, ca_max_t_in;
   logic [VB-1:0]     cs_min_v_ff, cs_min_v_in, cs_max_v_ff, cs_max_v_in;
   logic [TIME_W-1:0] cs_min_t_ff, cs_min_t_in, cs_max_t_ff, cs_max_t_in;

   logic [NORM_W-1:0] norm_ff, norm_in;
   logic              flat_ff, flat_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [NORM_W-1:0] rsp_norm_ff, rsp_norm_in;
   logic [SAMPLE_W-1:0] rsp_min_ff, rsp_min_in, rsp_max_ff, rsp_max_in;
   logic              rsp_flat_ff, rsp_flat_in;

   // store write controls
   logic              seed_wr, ent_wr;
   logic [IDX_W-1:0]  wr_idx;
   logic [VB-1:0]     wr_min_v, wr_max_v;
   logic [TIME_W-1:0] wr_min_t, wr_max_t;

   // queue head fields
   logic              head_seed;
   logic [VB-1:0]     head_v;
   logic [TIME_W-1:0] head_t;

   // entry at the walk index
   logic [VB-1:0]     ent_min_v, ent_max_v;
   logic [TIME_W-1:0] ent_min_t, ent_max_t;
   logic [VB-1:0]     aged_min_v, aged_max_v, shr_min_v, shr_max_v;
   logic [TIME_W-1:0] aged_min_t, aged_max_t, shr_min_t, shr_max_t;
   logic [TIME_W-1:0] delta_min, delta_max;
   logic [LIMIT_W-1:0] lim_sel;
   logic [THR_W-1:0]  thr_prod;
   logic [VB-1:0]     w0_min, w0_max;
   logic              out_free;

   assign head_seed = fifo_data[ENTRY_W-1];
   assign head_v    = fifo_data[TIME_W +: VB];
   assign head_t    = fifo_data[TIME_W-1:0];

   assign ent_min_v = min_v_ff[idx_ff];
   assign ent_min_t = min_t_ff[idx_ff];
   assign ent_max_v = max_v_ff[idx_ff];
   assign ent_max_t = max_t_ff[idx_ff];
   assign w0_min    = min_v_ff[0];
   assign w0_max    = max_v_ff[0];

   // limit of the window being walked; the shortest limit covers the rest
   assign lim_sel  = (idx_ff == IDX_W'(0)) ? limits.lim_long :
                     (idx_ff == IDX_W'(1)) ? limits.lim_mid  : limits.lim_short;
   assign thr_prod = THR_W'({1'b0, lim_sel} + 17'd1) * THR_W'(TICKS_PER_MINUTE);

   assign delta_min = cur_t_ff - ent_min_t;
   assign delta_max = cur_t_ff - ent_max_t;

   // age replacement, then shrink against the shorter window
   assign aged_min_v = age_min_ff ? ca_min_v_ff : ent_min_v;
   assign aged_min_t = age_min_ff ? ca_min_t_ff : ent_min_t;
   assign aged_max_v = age_max_ff ? ca_max_v_ff : ent_max_v;
   assign aged_max_t = age_max_ff ? ca_max_t_ff : ent_max_t;
   assign shr_min_v  = (aged_min_v > cs_min_v_ff) ? cs_min_v_ff : aged_min_v;
   assign shr_min_t  = (aged_min_v > cs_min_v_ff) ? cs_min_t_ff : aged_min_t;
   assign shr_max_v  = (aged_max_v < cs_max_v_ff) ? cs_max_v_ff : aged_max_v;
   assign shr_max_t  = (aged_max_v < cs_max_v_ff) ? cs_max_t_ff : aged_max_t;

   assign div_num  = cur_v_ff - w0_min;
   assign div_den  = w0_max - w0_min;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normalized = rsp_norm_ff;
   assign rsp_window_min = rsp_min_ff;
   assign rsp_window_max = rsp_max_ff;
   assign rsp_flat       = rsp_flat_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cur_v_in     = cur_v_ff;
      cur_t_in     = cur_t_ff;
      thr_in       = thr_ff;
      age_min_in   = age_min_ff;
      age_max_in   = age_max_ff;
      ca_min_v_in  = ca_min_v_ff;
      ca_min_t_in  = ca_min_t_ff;
      ca_max_v_in  = ca_max_v_ff;
      ca_max_t_in  = ca_max_t_ff;
      cs_min_v_in  = cs_min_v_ff;
      cs_min_t_in  = cs_min_t_ff;
      cs_max_v_in  = cs_max_v_ff;
      cs_max_t_in  = cs_max_t_ff;
      norm_in      = norm_ff;
      flat_in      = flat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_norm_in  = rsp_norm_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_flat_in  = rsp_flat_ff;
      fifo_pop     = 1'b0;
      div_start    = 1'b0;
      seed_wr      = 1'b0;
      ent_wr       = 1'b0;
      wr_idx       = idx_ff;
      wr_min_v     = shr_min_v;
      wr_min_t     = shr_min_t;
      wr_max_v     = shr_max_v;
      wr_max_t     = shr_max_t;

      unique case (state_ff)
         ST_IDLE: begin
            wr_min_v = head_v;
            wr_min_t = head_t;
            wr_max_v = head_v;
            wr_max_t = head_t;
            if (!fifo_empty) begin
               fifo_pop = 1'b1;
               cur_v_in = head_v;
               cur_t_in = head_t;
               if (head_seed) begin
                  seed_wr  = 1'b1;
                  state_in = ST_CLAMP;
               end else begin
                  ent_wr      = 1'b1;
                  wr_idx      = IDX_W'(WINDOWS - 1);
                  ca_min_v_in = head_v;
                  ca_min_t_in = head_t;
                  ca_max_v_in = head_v;
                  ca_max_t_in = head_t;
                  cs_min_v_in = head_v;
                  cs_min_t_in = head_t;
                  cs_max_v_in = head_v;
                  cs_max_t_in = head_t;
                  idx_in      = IDX_W'(WINDOWS - 2);
                  state_in    = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            thr_in   = TIME_W'(thr_prod);
            state_in = ST_AGE;
         end
         ST_AGE: begin
            age_min_in = (cur_t_ff > ent_min_t) && (delta_min >= thr_ff);
            age_max_in = (cur_t_ff > ent_max_t) && (delta_max >= thr_ff);
            state_in   = ST_SHRINK;
         end
         ST_SHRINK: begin
            ent_wr      = 1'b1;
            ca_min_v_in = aged_min_v;
            ca_min_t_in = aged_min_t;
            ca_max_v_in = aged_max_v;
            ca_max_t_in = aged_max_t;
            cs_min_v_in = shr_min_v;
            cs_min_t_in = shr_min_t;
            cs_max_v_in = shr_max_v;
            cs_max_t_in = shr_max_t;
            if (idx_ff == '0) begin
               state_in = ST_CLAMP;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_CLAMP: begin
            flat_in = 1'b0;
            norm_in = '0;
            if (!(w0_max > w0_min)) begin
               flat_in  = 1'b1;
               state_in = ST_DONE;
            end else if (cur_v_ff <= w0_min) begin
               state_in = ST_DONE;
            end else if (cur_v_ff >= w0_max) begin
               norm_in  = NORM_ONE;
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               norm_in  = div_quot;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_norm_in  = norm_ff;
               rsp_flat_in  = flat_ff;
               rsp_min_in   = SAMPLE_W'($signed({~w0_min[VB-1], w0_min[VB-2:0]}));
               rsp_max_in   = SAMPLE_W'($signed({~w0_max[VB-1], w0_max[VB-2:0]}));
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload and result fields
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cur_v_ff    <= cur_v_in;
      cur_t_ff    <= cur_t_in;
      thr_ff      <= thr_in;
      age_min_ff  <= age_min_in;
      age_max_ff  <= age_max_in;
      ca_min_v_ff <= ca_min_v_in;
      ca_min_t_ff <= ca_min_t_in;
      ca_max_v_ff <= ca_max_v_in;
      ca_max_t_ff <= ca_max_t_in;
      cs_min_v_ff <= cs_min_v_in;
      cs_min_t_ff <= cs_min_t_in;
      cs_max_v_ff <= cs_max_v_in;
      cs_max_t_ff <= cs_max_t_in;
      norm_ff     <= norm_in;
      flat_ff     <= flat_in;
      rsp_norm_ff <= rsp_norm_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_flat_ff <= rsp_flat_in;
   end

   // window stores: all entries on a seed, one entry per walk step
   always_ff @(posedge clock) begin
      if (seed_wr) begin
         for (int w = 0; w < WINDOWS; w++) begin
            min_v_ff[w] <= wr_min_v;
            min_t_ff[w] <= wr_min_t;
            max_v_ff[w] <= wr_max_v;
            max_t_ff[w] <= wr_max_t;
         end
      end else if (ent_wr) begin
         min_v_ff[wr_idx] <= wr_min_v;
         min_t_ff[wr_idx] <= wr_min_t;
         max_v_ff[wr_idx] <= wr_max_v;
         max_t_ff[wr_idx] <= wr_max_t;
      end
   end

endmodule

// ===== rtl/cascaded_window_min_max_normalizer_core.sv =====
// Usage
// Samples enter on the req_ channel (req_valid / req_stall) and each yields
// exactly one beat on the rsp_ channel (rsp_valid / rsp_stall), in order.
// A beat moves at a clock edge where valid is high and stall is low.
// The age limits are written on the csr_ channel (csr_valid / csr_ready,
// csr_index, csr_data low 16 bits); csr_ready is always high. Write them
// only while no sample is in flight.
// Processing: the seed sample goes from the queue straight to the clamp;
// other samples first walk the windows from the shortest to the longest,
// each in a multiply, an age and a shrink step, then clamp to 0 or one or
// start the one-bit-per-cycle divider for the 16 quotient bits; the
// result then waits in the done state until the output is free.
// A two-beat queue sits between the front end and the window engine, so
// samples are taken while a result waits. When rsp_stall is high the result
// holds and the engine waits; req_stall rises once the queue is full.
// Reset (synchronous) restores the default limits, empties the queue and
// makes the next sample seed every window.
module cascaded_window_min_max_normalizer_core import cwmm_pkg::*; #(
   parameter int WINDOWS          = 4,
   parameter int VALUE_BITS       = 32,
   parameter int TICKS_PER_MINUTE = 600000000
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_value,
   input  logic [TIME_W-1:0]          req_sample_time,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [NORM_W-1:0]          rsp_normalized,
   output logic signed [SAMPLE_W-1:0] rsp_window_min,
   output logic signed [SAMPLE_W-1:0] rsp_window_max,
   output logic                       rsp_flat,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   localparam int ENTRY_W = 1 + VALUE_BITS + TIME_W;

   limits_type              limits_ff, limits_in;
   logic                    q_push, q_full, q_pop, q_empty;
   logic [ENTRY_W-1:0]      q_push_data, q_pop_data;
   logic                    div_start, div_done;
   logic [VALUE_BITS-1:0]   div_num, div_den;
   logic [NORM_W-1:0]       div_quot;

   assign csr_ready = 1'b1;

   // limit registers
   always_comb begin
      limits_in = limits_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LIM_LONG:  limits_in.lim_long  = csr_data[LIMIT_W-1:0];
            CSR_LIM_MID:   limits_in.lim_mid   = csr_data[LIMIT_W-1:0];
            CSR_LIM_SHORT: limits_in.lim_short = csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.lim_long  <= LIM_LONG_RST;
         limits_ff.lim_mid   <= LIM_MID_RST;
         limits_ff.lim_short <= LIM_SHORT_RST;
      end else begin
         limits_ff <= limits_in;
      end
   end

   cwmm_front #(
      .VALUE_BITS (VALUE_BITS),
      .ENTRY_W    (ENTRY_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_value (req_sample_value),
      .req_sample_time  (req_sample_time),
      .push             (q_push),
      .push_data        (q_push_data),
      .full             (q_full)
   );

   cwmm_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (2)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   cwmm_window #(
      .WINDOWS          (WINDOWS),
      .VALUE_BITS       (VALUE_BITS),
      .TICKS_PER_MINUTE (TICKS_PER_MINUTE),
      .ENTRY_W          (ENTRY_W)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .limits         (limits_ff),
      .fifo_empty     (q_empty),
      .fifo_data      (q_pop_data),
      .fifo_pop       (q_pop),
      .div_start      (div_start),
      .div_num        (div_num),
      .div_den        (div_den),
      .div_done       (div_done),
      .div_quot       (div_quot),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_normalized (rsp_normalized),
      .rsp_window_min (rsp_window_min),
      .rsp_window_max (rsp_window_max),
      .rsp_flat       (rsp_flat)
   );

   cwmm_div #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

endmodule

// ===== rtl/cwmm_checker.sv =====
// Port-level checks for the normalizer core, attached by the bind below.
// Depends on cwmm_pkg and the top-level port list.
module cwmm_checker import cwmm_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [NORM_W-1:0]          rsp_normalized,
   input logic signed [SAMPLE_W-1:0] rsp_window_min,
   input logic signed [SAMPLE_W-1:0] rsp_window_max,
   input logic                       rsp_flat
);

   // a flat window always reports zero
   a_flat_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flat) |-> (rsp_normalized == '0))
      else $error("flat window with nonzero normalized value");

   // a window that is not flat has max above min
   a_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_flat) |-> (rsp_window_max > rsp_window_min))
      else $error("non-flat result with max not above min");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_normalized)
         && $stable(rsp_window_min) && $stable(rsp_window_max) && $stable(rsp_flat)))
      else $error("stalled result changed");

endmodule

bind cascaded_window_min_max_normalizer_core cwmm_checker u_checker (.*);
